/* rtl/frn_pkg.sv */
// ----------------------------------------------------------------------------
// frn_pkg: shared types and constants for fraction reduction
// Widths, sequencer states and the control/status bundles between modules.
// ----------------------------------------------------------------------------
package frn_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int DEN_WIDTH  = DATA_WIDTH - 1;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] mag_t;
  typedef logic [CNT_WIDTH-1:0]  cnt_t;

  localparam cnt_t CNT_LAST = cnt_t'(DATA_WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_AEVEN,
    ST_GCD,
    ST_DIVN,
    ST_DIVD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic inf;
    logic take;
  } core_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } core_sts_t;

  typedef struct packed {
    logic ge;
    mag_t diff;
  } alu_res_t;

endpackage

/* rtl/frn_alu.sv */
// ----------------------------------------------------------------------------
// frn_alu: shared compare and subtract unit
// Returns x >= y and the magnitude of their difference, larger minus smaller.
// ----------------------------------------------------------------------------
module frn_alu (
  input  frn_pkg::mag_t     x,
  input  frn_pkg::mag_t     y,
  output frn_pkg::alu_res_t res
);
  import frn_pkg::*;

  logic ge;
  mag_t mx;
  mag_t mn;

  always_comb begin
    ge       = (x >= y);
    mx       = ge ? x : y;
    mn       = ge ? y : x;
    res.ge   = ge;
    res.diff = mag_t'(mx - mn);
  end

endmodule

/* rtl/frn_core.sv */
// ----------------------------------------------------------------------------
// frn_core: GCD and exact division sequencer
// Binary GCD of two magnitudes, then restoring division of each by the GCD,
// all on one shared compare/subtract unit.
// ----------------------------------------------------------------------------
module frn_core (
  input  logic                clk,
  input  logic                rst,
  input  frn_pkg::core_ctl_t  ctl,
  input  frn_pkg::mag_t       n_mag,
  input  frn_pkg::mag_t       d_mag,
  output frn_pkg::core_sts_t  sts,
  output frn_pkg::mag_t       num_quo,
  output frn_pkg::mag_t       den_quo
);
  import frn_pkg::*;

  state_t   state;
  state_t   state_next;
  mag_t     a;
  mag_t     b;
  cnt_t     k;
  mag_t     g;
  mag_t     r;
  mag_t     q;
  mag_t     nm;
  mag_t     dm;
  mag_t     nq;
  cnt_t     cnt;
  mag_t     r_sh;
  mag_t     alu_x;
  mag_t     alu_y;
  alu_res_t alu;

  frn_alu u_alu (
    .x   (alu_x),
    .y   (alu_y),
    .res (alu)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          if (ctl.inf) begin
            state_next = ST_DONE;
          end else if (n_mag == '0) begin
            state_next = ST_DIVN;
          end else begin
            state_next = ST_TWOS;
          end
        end
      end
      ST_TWOS: begin
        if ((a[0] | b[0]) == 1'b1) begin
          state_next = ST_AEVEN;
        end
      end
      ST_AEVEN: begin
        if (a[0]) begin
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (b == '0) begin
          state_next = ST_DIVN;
        end
      end
      ST_DIVN: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_DIVD;
        end
      end
      ST_DIVD: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ctl.take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and shared unit operand select
  always_comb begin
    r_sh  = {r[DATA_WIDTH-2:0], q[DATA_WIDTH-1]};
    alu_x = a;
    alu_y = b;
    case (state)
      ST_DIVN, ST_DIVD: begin
        alu_x = r_sh;
        alu_y = g;
      end
      default: begin
        alu_x = a;
        alu_y = b;
      end
    endcase
    sts.idle = (state == ST_IDLE);
    sts.done = (state == ST_DONE);
    num_quo  = nq;
    den_quo  = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (ctl.start) begin
          a   <= n_mag;
          b   <= d_mag;
          nm  <= n_mag;
          dm  <= d_mag;
          nq  <= '0;
          k   <= '0;
          g   <= d_mag;
          r   <= '0;
          q   <= n_mag;
          cnt <= '0;
        end
      end
      ST_TWOS: begin
        if ((a[0] | b[0]) == 1'b0) begin
          a <= a >> 1;
          b <= b >> 1;
          k <= cnt_t'(k + 1'b1);
        end
      end
      ST_AEVEN: begin
        if (!a[0]) begin
          a <= a >> 1;
        end
      end
      ST_GCD: begin
        if (b == '0) begin
          g   <= a << k;
          r   <= '0;
          q   <= nm;
          cnt <= '0;
        end else if (!b[0]) begin
          b <= b >> 1;
        end else begin
          a <= alu.ge ? b : a;
          b <= alu.diff;
        end
      end
      ST_DIVN, ST_DIVD: begin
        r   <= alu.ge ? alu.diff : r_sh;
        q   <= {q[DATA_WIDTH-2:0], alu.ge};
        cnt <= cnt_t'(cnt + 1'b1);
        if (state == ST_DIVN && cnt == CNT_LAST) begin
          nq  <= {q[DATA_WIDTH-2:0], alu.ge};
          r   <= '0;
          q   <= dm;
          cnt <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  a_gcd_odd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GCD) |-> a[0])
    else $error("GCD operand a lost its odd value");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVN || state == ST_DIVD) |-> (r < g))
    else $error("division remainder not below divisor");

  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !ctl.take) |=> (state == ST_DONE && $stable(q) && $stable(nq)))
    else $error("finished quotients not held until taken");

endmodule

/* rtl/fraction_reduce_normalize.sv */
// ----------------------------------------------------------------------------
// fraction_reduce_normalize: canonical form of a signed fraction
// Input beat: numerator and denominator on in_valid/in_ready. Output beat:
// is_infinity, reduced_num, reduced_den on out_valid/out_ready, one per input.
// A zero denominator gives 1/0 with is_infinity set; otherwise the sign moves
// to the numerator and both parts are divided by their GCD, so 0/d gives 0/1.
// The sequencer takes one fraction at a time; in_ready is low while it works.
// Per fraction: a load step, then binary GCD (one halving or one
// compare-and-subtract per cycle), then restoring division of the numerator
// and then the denominator, one quotient bit per cycle, all through the
// single compare/subtract unit; the done state then hands the result to the
// output register once it is free. A zero denominator skips the arithmetic.
// The output register holds a finished beat while out_ready is low; the next
// fraction may be accepted meanwhile and waits in the sequencer once done.
// Synchronous reset empties the output register and returns the sequencer to
// idle; the arithmetic and data registers are not reset.
// ----------------------------------------------------------------------------
module fraction_reduce_normalize (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [frn_pkg::DATA_WIDTH-1:0] numerator,
  input  logic signed [frn_pkg::DATA_WIDTH-1:0] denominator,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  is_infinity,
  output logic signed [frn_pkg::DATA_WIDTH-1:0] reduced_num,
  output logic        [frn_pkg::DEN_WIDTH-1:0]  reduced_den
);
  import frn_pkg::*;

  core_ctl_t ctl;
  core_sts_t sts;
  mag_t      n_raw;
  mag_t      d_raw;
  mag_t      n_mag;
  mag_t      d_mag;
  mag_t      num_quo;
  mag_t      den_quo;
  logic      accept;
  logic      inf_q;
  logic      neg_q;

  always_comb begin
    n_raw     = mag_t'(numerator);
    d_raw     = mag_t'(denominator);
    n_mag     = n_raw[DATA_WIDTH-1] ? mag_t'(~n_raw + mag_t'(1)) : n_raw;
    d_mag     = d_raw[DATA_WIDTH-1] ? mag_t'(~d_raw + mag_t'(1)) : d_raw;
    in_ready  = sts.idle;
    accept    = in_valid && in_ready;
    ctl.start = accept;
    ctl.inf   = (d_raw == '0);
    ctl.take  = sts.done && (!out_valid || out_ready);
  end

  frn_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .n_mag   (n_mag),
    .d_mag   (d_mag),
    .sts     (sts),
    .num_quo (num_quo),
    .den_quo (den_quo)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      inf_q <= ctl.inf;
      neg_q <= n_raw[DATA_WIDTH-1] ^ d_raw[DATA_WIDTH-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      is_infinity <= inf_q;
      if (inf_q) begin
        reduced_num <= DATA_WIDTH'(1);
        reduced_den <= '0;
      end else begin
        reduced_num <= neg_q ? DATA_WIDTH'(~num_quo + mag_t'(1)) : num_quo;
        reduced_den <= den_quo[DEN_WIDTH-1:0];
      end
    end
  end

  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("sequencer ready again straight after accepting a beat");

endmodule
